FILE: sv/kpg_pkg.sv
`default_nettype none
package kpg_pkg;

  localparam int MAX_PARTS   = 32;
  localparam int MAX_PEAKS   = 64;
  localparam int MAX_LINKS   = 32;
  localparam int MAX_OBJECTS = 32;

  localparam int PART_W = 5;
  localparam int PEAK_W = 6;
  localparam int NODE_W = PART_W + PEAK_W;
  localparam int NODE_COUNT = MAX_PARTS * MAX_PEAKS;
  localparam int CONN_AW = PART_W + 1 + PEAK_W;
  localparam int CONN_DEPTH = 1 << CONN_AW;
  localparam int SLOT_AW = 10;
  localparam int SLOT_DEPTH = MAX_OBJECTS * MAX_PARTS;
  localparam int QPTR_W = NODE_W + 1;

  localparam logic [2:0] CMD_SET_LINK  = 3'd0;
  localparam logic [2:0] CMD_SET_COUNT = 3'd1;
  localparam logic [2:0] CMD_SET_CONN  = 3'd2;
  localparam logic [2:0] CMD_RUN       = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;

  localparam logic [1:0] REG_MAX_OBJECTS = 2'd0;
  localparam logic [1:0] REG_NUM_LINKS   = 2'd1;
  localparam logic [1:0] REG_NUM_PARTS   = 2'd2;

  localparam logic [6:0] PEAK_NONE = 7'h7F;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_SEED,
    S_SEED_CHK,
    S_POP,
    S_NODE,
    S_EDGE,
    S_CONN,
    S_SEEN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: sv/keypoint_graph_grouping_top.sv
`default_nettype none
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_command .. in_object
// out     | output    | out_valid, out_ready, out_num_groups, out_slot_peak, out_accepted
// cfg     | input     | cfg_we, cfg_index, cfg_data (write only, no wait)
//
// Load commands (set link, set count, set connection) answer straight from idle; a read
// passes through S_READ first, for the registered read of the object slot memory.
// A run first sweeps the visited map and slot memory, then walks every peak as a seed
// (S_SEED and S_SEED_CHK, then S_POP when a seed's queue runs empty) and, per visited node,
// passes S_POP, S_NODE and a closing S_EDGE, plus one S_EDGE for each link direction, with
// S_CONN, and S_SEEN when a connection exists, added when its endpoint matches.
// Reset is synchronous, active low; it clears control state, part counts and the object count.
// A new word is taken only when the output register is empty or its result leaves in the
// same cycle; a result held back by out_ready stalls the input.
module keypoint_graph_grouping_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_command,
  input  wire logic [4:0] in_link,
  input  wire logic [4:0] in_part_a,
  input  wire logic [4:0] in_part_b,
  input  wire logic [4:0] in_part,
  input  wire logic [6:0] in_count,
  input  wire logic       in_direction,
  input  wire logic [5:0] in_peak,
  input  wire logic signed [6:0] in_target,
  input  wire logic [4:0] in_object,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      out_num_groups,
  output logic signed [6:0] out_slot_peak,
  output logic            out_accepted
);

  localparam int NW = kpg_pkg::NODE_W;
  localparam int QW = kpg_pkg::QPTR_W;

  kpg_pkg::state_t state_r, state_nxt;

  // Configuration registers.
  logic [5:0] max_objects_r, num_links_r, num_parts_r;
  logic [5:0] limit, links, parts;

  // Small tables held in flip-flops; each is read at one sequencer address.
  logic [4:0] link_a_r [kpg_pkg::MAX_LINKS];
  logic [4:0] link_b_r [kpg_pkg::MAX_LINKS];
  logic [6:0] part_cnt_r [kpg_pkg::MAX_PARTS];

  // Sequencer counters and holding registers.
  logic [10:0]   sweep_r, sweep_nxt;
  logic [5:0]    c_r, c_nxt;
  logic [6:0]    i_r, i_nxt;
  logic [5:0]    formed_r, formed_nxt;
  logic [5:0]    count_r, count_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [NW-1:0] node_r, node_nxt, nb_r, nb_nxt;
  logic [5:0]    k_r, k_nxt;
  logic          dir_r, dir_nxt;
  logic [4:0]    obj_r, obj_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_cnt_r, out_cnt_nxt;
  logic [6:0]    out_slot_r, out_slot_nxt;
  logic          out_acc_r, out_acc_nxt;

  // Memory ports.
  logic                           conn_we;
  logic [kpg_pkg::CONN_AW-1:0]    conn_wa, conn_ra;
  logic [6:0]                     conn_wd, conn_rd;
  logic                           seen_we, seen_wd, seen_rd;
  logic [NW-1:0]                  seen_wa, seen_ra;
  logic                           q_we;
  logic [NW-1:0]                  q_wa, q_ra, q_wd, q_rd;
  logic                           slot_we;
  logic [kpg_pkg::SLOT_AW-1:0]    slot_wa, slot_ra;
  logic [6:0]                     slot_wd, slot_rd;

  logic       accept;
  logic [4:0] cn, endpoint, other;
  logic [5:0] pn;
  logic [6:0] cnt;
  logic       last_dir;

  assign limit = (max_objects_r > 6'(kpg_pkg::MAX_OBJECTS)) ? 6'(kpg_pkg::MAX_OBJECTS)
                                                            : max_objects_r;
  assign links = (num_links_r > 6'(kpg_pkg::MAX_LINKS)) ? 6'(kpg_pkg::MAX_LINKS) : num_links_r;
  assign parts = (num_parts_r > 6'(kpg_pkg::MAX_PARTS)) ? 6'(kpg_pkg::MAX_PARTS) : num_parts_r;

  assign in_ready = (state_r == kpg_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign cn       = node_r[NW-1:kpg_pkg::PEAK_W];
  assign pn       = node_r[kpg_pkg::PEAK_W-1:0];
  assign cnt      = part_cnt_r[c_r[4:0]];
  assign endpoint = dir_r ? link_b_r[k_r[4:0]] : link_a_r[k_r[4:0]];
  assign other    = dir_r ? link_a_r[k_r[4:0]] : link_b_r[k_r[4:0]];
  assign last_dir = dir_r;

  kpg_ram #(.WIDTH(7), .DEPTH(kpg_pkg::CONN_DEPTH)) u_conn (
    .clk(clk), .we(conn_we), .waddr(conn_wa), .wdata(conn_wd), .raddr(conn_ra), .rdata(conn_rd)
  );
  kpg_ram #(.WIDTH(1), .DEPTH(kpg_pkg::NODE_COUNT)) u_seen (
    .clk(clk), .we(seen_we), .waddr(seen_wa), .wdata(seen_wd), .raddr(seen_ra), .rdata(seen_rd)
  );
  kpg_ram #(.WIDTH(NW), .DEPTH(kpg_pkg::NODE_COUNT)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
  );
  kpg_ram #(.WIDTH(7), .DEPTH(kpg_pkg::SLOT_DEPTH)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_wa), .wdata(slot_wd), .raddr(slot_ra), .rdata(slot_rd)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpg_pkg::S_IDLE: begin
        if (accept && in_command == kpg_pkg::CMD_RUN) begin
          state_nxt = kpg_pkg::S_CLEAR;
        end else if (accept && in_command == kpg_pkg::CMD_READ) begin
          state_nxt = kpg_pkg::S_READ;
        end
      end
      kpg_pkg::S_READ:  state_nxt = kpg_pkg::S_IDLE;
      kpg_pkg::S_CLEAR: begin
        if (sweep_r == 11'(kpg_pkg::NODE_COUNT - 1)) begin
          state_nxt = kpg_pkg::S_SEED;
        end
      end
      kpg_pkg::S_SEED: begin
        if (!(c_r < parts && formed_r < limit)) begin
          state_nxt = kpg_pkg::S_DONE;
        end else if (i_r < cnt) begin
          state_nxt = kpg_pkg::S_SEED_CHK;
        end
      end
      kpg_pkg::S_SEED_CHK: state_nxt = seen_rd ? kpg_pkg::S_SEED : kpg_pkg::S_POP;
      kpg_pkg::S_POP:      state_nxt = (head_r < tail_r) ? kpg_pkg::S_NODE : kpg_pkg::S_SEED;
      kpg_pkg::S_NODE:     state_nxt = kpg_pkg::S_EDGE;
      kpg_pkg::S_EDGE: begin
        if (k_r >= links) begin
          state_nxt = kpg_pkg::S_POP;
        end else if (endpoint == cn) begin
          state_nxt = kpg_pkg::S_CONN;
        end
      end
      kpg_pkg::S_CONN:  state_nxt = conn_rd[6] ? kpg_pkg::S_EDGE : kpg_pkg::S_SEEN;
      kpg_pkg::S_SEEN:  state_nxt = kpg_pkg::S_EDGE;
      kpg_pkg::S_DONE:  state_nxt = kpg_pkg::S_IDLE;
      default:          state_nxt = kpg_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    sweep_nxt = sweep_r;  c_nxt = c_r;  i_nxt = i_r;  formed_nxt = formed_r;
    count_nxt = count_r;  head_nxt = head_r;  tail_nxt = tail_r;
    node_nxt = node_r;  nb_nxt = nb_r;  k_nxt = k_r;  dir_nxt = dir_r;  obj_nxt = obj_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cnt_nxt = out_cnt_r;  out_slot_nxt = out_slot_r;  out_acc_nxt = out_acc_r;
    conn_we = 1'b0;
    conn_wa = {in_link, in_direction, in_peak};
    conn_wd = in_target[6] ? kpg_pkg::PEAK_NONE : 7'(in_target);
    conn_ra = {k_r[4:0], dir_r, pn};
    seen_we = 1'b0;  seen_wa = sweep_r;  seen_wd = 1'b0;
    seen_ra = {c_r[4:0], i_r[5:0]};
    q_we = 1'b0;  q_wa = tail_r[NW-1:0];  q_wd = nb_r;  q_ra = head_r[NW-1:0];
    slot_we = 1'b0;  slot_wa = sweep_r[kpg_pkg::SLOT_AW-1:0];  slot_wd = kpg_pkg::PEAK_NONE;
    slot_ra = {in_object, in_part};

    case (state_r)
      kpg_pkg::S_IDLE: begin
        if (accept) begin
          obj_nxt = in_object;
          case (in_command)
            kpg_pkg::CMD_SET_LINK, kpg_pkg::CMD_SET_CONN: begin
              conn_we = (in_command == kpg_pkg::CMD_SET_CONN);
              out_valid_nxt = 1'b1;  out_cnt_nxt = count_r;
              out_slot_nxt = kpg_pkg::PEAK_NONE;  out_acc_nxt = 1'b1;
            end
            kpg_pkg::CMD_SET_COUNT: begin
              out_valid_nxt = 1'b1;  out_cnt_nxt = count_r;
              out_slot_nxt = kpg_pkg::PEAK_NONE;
              out_acc_nxt = (in_count <= 7'(kpg_pkg::MAX_PEAKS));
            end
            kpg_pkg::CMD_RUN: begin
              sweep_nxt = '0;
            end
            kpg_pkg::CMD_READ: begin
            end
            default: begin
              out_valid_nxt = 1'b1;  out_cnt_nxt = count_r;
              out_slot_nxt = kpg_pkg::PEAK_NONE;  out_acc_nxt = 1'b0;
            end
          endcase
        end
      end
      kpg_pkg::S_READ: begin
        // Objects beyond the last run's count were never formed and read as none.
        out_valid_nxt = 1'b1;  out_cnt_nxt = count_r;  out_acc_nxt = 1'b1;
        out_slot_nxt = ({1'b0, obj_r} < count_r) ? slot_rd : kpg_pkg::PEAK_NONE;
      end
      kpg_pkg::S_CLEAR: begin
        seen_we = 1'b1;
        slot_we = (sweep_r < 11'(kpg_pkg::SLOT_DEPTH));
        sweep_nxt = sweep_r + 11'd1;
        c_nxt = '0;  i_nxt = '0;  formed_nxt = '0;
      end
      kpg_pkg::S_SEED: begin
        if (c_r < parts && formed_r < limit && i_r >= cnt) begin
          c_nxt = c_r + 6'd1;
          i_nxt = '0;
        end
      end
      kpg_pkg::S_SEED_CHK: begin
        if (seen_rd) begin
          i_nxt = i_r + 7'd1;
        end else begin
          seen_we = 1'b1;  seen_wa = {c_r[4:0], i_r[5:0]};  seen_wd = 1'b1;
          q_we = 1'b1;  q_wa = '0;  q_wd = {c_r[4:0], i_r[5:0]};
          head_nxt = '0;  tail_nxt = QW'(1);
        end
      end
      kpg_pkg::S_POP: begin
        if (head_r < tail_r) begin
          head_nxt = head_r + QW'(1);
        end else begin
          formed_nxt = formed_r + 6'd1;
          i_nxt = i_r + 7'd1;
        end
      end
      kpg_pkg::S_NODE: begin
        node_nxt = q_rd;
        slot_we = 1'b1;
        slot_wa = {formed_r[4:0], q_rd[NW-1:kpg_pkg::PEAK_W]};
        slot_wd = {1'b0, q_rd[kpg_pkg::PEAK_W-1:0]};
        k_nxt = '0;  dir_nxt = 1'b0;
      end
      kpg_pkg::S_EDGE: begin
        if (k_r < links && endpoint != cn) begin
          dir_nxt = !dir_r;
          if (last_dir) begin
            k_nxt = k_r + 6'd1;
          end
        end
      end
      kpg_pkg::S_CONN: begin
        nb_nxt = {other, conn_rd[5:0]};
        seen_ra = {other, conn_rd[5:0]};
        if (conn_rd[6]) begin
          dir_nxt = !dir_r;
          if (last_dir) begin
            k_nxt = k_r + 6'd1;
          end
        end
      end
      kpg_pkg::S_SEEN: begin
        if (!seen_rd) begin
          seen_we = 1'b1;  seen_wa = nb_r;  seen_wd = 1'b1;
          q_we = 1'b1;
          tail_nxt = tail_r + QW'(1);
        end
        dir_nxt = !dir_r;
        if (last_dir) begin
          k_nxt = k_r + 6'd1;
        end
      end
      kpg_pkg::S_DONE: begin
        count_nxt = formed_r;
        out_valid_nxt = 1'b1;  out_cnt_nxt = formed_r;
        out_slot_nxt = kpg_pkg::PEAK_NONE;  out_acc_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kpg_pkg::S_IDLE;
      max_objects_r <= 6'(kpg_pkg::MAX_OBJECTS);
      num_links_r <= '0;
      num_parts_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
      for (int p = 0; p < kpg_pkg::MAX_PARTS; p++) begin
        part_cnt_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cfg_we) begin
        case (cfg_index)
          kpg_pkg::REG_MAX_OBJECTS: max_objects_r <= cfg_data;
          kpg_pkg::REG_NUM_LINKS:   num_links_r <= cfg_data;
          kpg_pkg::REG_NUM_PARTS:   num_parts_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept && in_command == kpg_pkg::CMD_SET_COUNT &&
          in_count <= 7'(kpg_pkg::MAX_PEAKS)) begin
        part_cnt_r[in_part] <= in_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    sweep_r <= sweep_nxt;  c_r <= c_nxt;  i_r <= i_nxt;  formed_r <= formed_nxt;
    node_r <= node_nxt;  nb_r <= nb_nxt;  k_r <= k_nxt;  dir_r <= dir_nxt;  obj_r <= obj_nxt;
    out_cnt_r <= out_cnt_nxt;  out_slot_r <= out_slot_nxt;  out_acc_r <= out_acc_nxt;
    if (accept && in_command == kpg_pkg::CMD_SET_LINK) begin
      link_a_r[in_link] <= in_part_a;
      link_b_r[in_link] <= in_part_b;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_num_groups = out_cnt_r;
  assign out_slot_peak  = out_slot_r;
  assign out_accepted   = out_acc_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == kpg_pkg::S_IDLE))
    else $error("ready raised outside idle");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kpg_pkg::S_EDGE || state_r == kpg_pkg::S_POP) |-> (head_r <= tail_r))
    else $error("queue head passed tail");
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= QW'(kpg_pkg::NODE_COUNT))
    else $error("queue overflow");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kpg_pkg::S_DONE) |=> (out_valid_r && out_cnt_r == count_r))
    else $error("run result missing");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 6'(kpg_pkg::MAX_OBJECTS))
    else $error("object count out of range");
`endif

endmodule
`default_nettype wire

FILE: sv/kpg_ram.sv
`default_nettype none
module kpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
